### src/legged_recovery_stand_sequencer_core_defines.svh
// Assertion macros of the recovery sequencer core.
`ifndef LEGGED_RECOVERY_STAND_SEQUENCER_CORE_DEFINES_SVH
`define LEGGED_RECOVERY_STAND_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LRSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define LRSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/lrss_pkg.sv
// Types, constants and pose tables of the recovery stand sequencer.
package lrss_pkg;

	localparam int NUM_LEGS   = 4;
	localparam int LEG_W      = 2;
	localparam int ANGLE_BITS = 16;
	localparam int JOINTS     = 3;
	localparam int ROW_W      = JOINTS * ANGLE_BITS;
	localparam int QUO_W      = 17;
	localparam int REM_W      = 13;
	localparam int CNT_W      = 16;
	localparam int RAMP_W     = 12;
	localparam int GAIN_W     = 10;

	localparam logic [LEG_W-1:0] LAST_LEG = LEG_W'(NUM_LEGS - 1);

	// operation codes
	localparam logic [1:0] OP_MEASURE = 2'd0;
	localparam logic [1:0] OP_ENTER   = 2'd1;
	localparam logic [1:0] OP_TICK    = 2'd2;

	// phase codes
	localparam logic [1:0] PH_STAND = 2'd0;
	localparam logic [1:0] PH_FOLD  = 2'd1;
	localparam logic [1:0] PH_ROLL  = 2'd2;

	// register indexes
	localparam logic [2:0] REG_STAND_RAMP  = 3'd0;
	localparam logic [2:0] REG_FOLD_RAMP   = 3'd1;
	localparam logic [2:0] REG_FOLD_SETTLE = 3'd2;
	localparam logic [2:0] REG_ROLL_RAMP   = 3'd3;
	localparam logic [2:0] REG_ROLL_SETTLE = 3'd4;
	localparam logic [2:0] REG_KP          = 3'd5;
	localparam logic [2:0] REG_KD          = 3'd6;

	// body height thresholds, Q3.12
	localparam logic signed [15:0] H_STAND_LO = 16'sd819;
	localparam logic signed [15:0] H_STAND_HI = 16'sd1843;
	localparam logic signed [15:0] H_TOO_LOW  = 16'sd409;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COPY,
		ST_RD,
		ST_DIFF,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef logic signed [ANGLE_BITS-1:0] angle_t;

	// Fixed target pose of a phase; phase code 3 falls back to fold.
	function automatic angle_t target_of(input logic [1:0] ph, input logic [LEG_W-1:0] leg,
			input int j);
		angle_t v;
		v = '0;
		case (ph)
			PH_STAND: begin
				case (j)
					0: v = 16'sd0;
					1: v = -16'sd3277;
					default: v = 16'sd6554;
				endcase
			end
			PH_ROLL: begin
				case (j)
					0: v = leg[0] ? 16'sd5325 : 16'sd6144;
					1: v = leg[0] ? -16'sd12698 : -16'sd6554;
					default: v = 16'sd11346;
				endcase
			end
			default: begin
				case (j)
					0: v = 16'sd0;
					1: v = -16'sd5734;
					default: v = 16'sd11059;
				endcase
			end
		endcase
		return v;
	endfunction

	// One leg's pose packed as a memory row, joint 0 in the low bits.
	function automatic logic [ROW_W-1:0] pose_row(input logic [1:0] ph,
			input logic [LEG_W-1:0] leg);
		return {target_of(ph, leg, 2), target_of(ph, leg, 1), target_of(ph, leg, 0)};
	endfunction

endpackage

### src/lrss_ram.sv
// Generic simple dual-port RAM with registered read.
module lrss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### src/legged_recovery_stand_sequencer_core.sv
// Top level of the quadruped recovery stand sequencer.
//
//  channel  direction  handshake          word
//  in       input      in_valid/in_stall  operation, leg, angles, height, flag
//  out      output     out_valid/out_stall one leg setpoint, phase, last flag
//  cfg      input      cfg_we             register index and data
//
// Measure stores one leg's row. Enter starts a sweep copying measured rows to start.
// Emitting tick: per leg a row read, diff, multiply, 17-step divider and output,
// for all four legs, then a pose row sweep when the phase change loads one.
// Reset clears control state; both angle memories read as zero until written.
// A stalled output holds the leg loop in its output step; input waits until idle.
`include "legged_recovery_stand_sequencer_core_defines.svh"

module legged_recovery_stand_sequencer_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          operation,
	input  logic [1:0]          leg_index,
	input  logic signed [15:0]  abduction_angle,
	input  logic signed [15:0]  hip_angle,
	input  logic signed [15:0]  knee_angle,
	input  logic signed [15:0]  trunk_height,
	input  logic                upside_down,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          leg_number,
	output logic signed [15:0]  abduction_target,
	output logic signed [15:0]  hip_target,
	output logic signed [15:0]  knee_target,
	output logic [9:0]          kp_out,
	output logic [9:0]          kd_out,
	output logic [1:0]          current_phase,
	output logic                last_leg,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [11:0]         cfg_data
);

	localparam int LW = lrss_pkg::LEG_W;
	localparam int AW = lrss_pkg::ANGLE_BITS;
	localparam int RW = lrss_pkg::ROW_W;
	localparam int NJ = lrss_pkg::JOINTS;
	localparam int QW = lrss_pkg::QUO_W;
	localparam int MW = lrss_pkg::REM_W;
	localparam int CW = lrss_pkg::CNT_W;
	localparam int NW = lrss_pkg::RAMP_W;
	localparam int GW = lrss_pkg::GAIN_W;

	// configuration registers
	logic [NW-1:0] stand_ramp_q, fold_ramp_q, fold_settle_q, roll_ramp_q, roll_settle_q;
	logic [GW-1:0] kp_q, kd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stand_ramp_q  <= NW'(250);
			fold_ramp_q   <= NW'(400);
			fold_settle_q <= NW'(700);
			roll_ramp_q   <= NW'(150);
			roll_settle_q <= NW'(150);
			kp_q          <= GW'(80);
			kd_q          <= GW'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				lrss_pkg::REG_STAND_RAMP:  stand_ramp_q  <= cfg_data;
				lrss_pkg::REG_FOLD_RAMP:   fold_ramp_q   <= cfg_data;
				lrss_pkg::REG_FOLD_SETTLE: fold_settle_q <= cfg_data;
				lrss_pkg::REG_ROLL_RAMP:   roll_ramp_q   <= cfg_data;
				lrss_pkg::REG_ROLL_SETTLE: roll_settle_q <= cfg_data;
				lrss_pkg::REG_KP:          kp_q          <= cfg_data[GW-1:0];
				lrss_pkg::REG_KD:          kd_q          <= cfg_data[GW-1:0];
				default: ;
			endcase
		end
	end

	// control state
	lrss_pkg::state_t state_q, state_d;
	logic [1:0]    phase_q;
	logic [CW-1:0] tick_q;
	logic [1:0]    ph_q;         // phase commanded by the current tick
	logic [NW-1:0] n_q;
	logic [CW-1:0] t_q;
	logic          early_q;
	logic          copy_pend_q;  // sweep owed after emission
	logic          copy_pose_q;  // sweep source: pose table or measured rows
	logic [1:0]    pose_ph_q;
	logic [LW:0]   cnt_q;
	logic [LW-1:0] leg_q;
	logic [4:0]    div_cnt_q;
	logic [lrss_pkg::NUM_LEGS-1:0] meas_vld_q;
	logic          start_vld_q;

	// per-joint datapath
	logic signed [AW-1:0] start_q [NJ];
	logic                 neg_q   [NJ];
	logic [QW-1:0]        mag_q   [NJ];
	logic [MW-1:0]        rem_q   [NJ];
	logic [QW-1:0]        quo_q   [NJ];

	// memories
	logic [RW-1:0] meas_rdata, start_rdata, start_wdata;
	logic          start_we;
	logic [LW-1:0] start_waddr, start_raddr, meas_raddr;
	logic          meas_we;

	wire accept_in = in_valid && !in_stall;
	wire out_free  = !out_valid || !out_stall;
	wire [1:0] ph_in = (phase_q == lrss_pkg::PH_STAND) ? lrss_pkg::PH_STAND :
	                   (phase_q == lrss_pkg::PH_ROLL)  ? lrss_pkg::PH_ROLL : lrss_pkg::PH_FOLD;
	wire [CW-1:0] tick_inc = (tick_q == {CW{1'b1}}) ? tick_q : tick_q + CW'(1);

	assign in_stall = (state_q != lrss_pkg::ST_IDLE);

	assign meas_we    = accept_in && (operation == lrss_pkg::OP_MEASURE);
	assign meas_raddr = cnt_q[LW-1:0];

	lrss_ram #(.WIDTH(RW), .DEPTH(lrss_pkg::NUM_LEGS)) u_meas_ram (
		.clk   (clk),
		.we    (meas_we),
		.waddr (leg_index[LW-1:0]),
		.wdata ({knee_angle, hip_angle, abduction_angle}),
		.raddr (meas_raddr),
		.rdata (meas_rdata)
	);

	// sweep writes start row cnt-1 from the row read in the previous cycle
	assign start_we    = (state_q == lrss_pkg::ST_COPY) && (cnt_q != '0);
	assign start_waddr = LW'(cnt_q - (LW+1)'(1));
	assign start_wdata = copy_pose_q ? lrss_pkg::pose_row(pose_ph_q, start_waddr) :
	                     (meas_vld_q[start_waddr] ? meas_rdata : '0);
	assign start_raddr = leg_q;

	lrss_ram #(.WIDTH(RW), .DEPTH(lrss_pkg::NUM_LEGS)) u_start_ram (
		.clk   (clk),
		.we    (start_we),
		.waddr (start_waddr),
		.wdata (start_wdata),
		.raddr (start_raddr),
		.rdata (start_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lrss_pkg::ST_IDLE: begin
				if (accept_in && operation == lrss_pkg::OP_ENTER) state_d = lrss_pkg::ST_COPY;
				else if (accept_in && operation == lrss_pkg::OP_TICK) begin
					if (ph_in != lrss_pkg::PH_STAND ||
					    ({4'b0, tick_q} * 20'd10) <= ({8'b0, stand_ramp_q} * 20'd7))
						state_d = lrss_pkg::ST_RD;
					else if (upside_down || trunk_height <= lrss_pkg::H_TOO_LOW)
						state_d = lrss_pkg::ST_COPY;
				end
			end
			lrss_pkg::ST_COPY: if (cnt_q == (LW+1)'(lrss_pkg::NUM_LEGS)) state_d = lrss_pkg::ST_IDLE;
			lrss_pkg::ST_RD:   state_d = lrss_pkg::ST_DIFF;
			lrss_pkg::ST_DIFF: state_d = lrss_pkg::ST_MUL;
			lrss_pkg::ST_MUL:  state_d = lrss_pkg::ST_DIV;
			lrss_pkg::ST_DIV:  if (div_cnt_q == 5'(QW - 1)) state_d = lrss_pkg::ST_OUT;
			lrss_pkg::ST_OUT: begin
				if (out_free) begin
					if (leg_q != lrss_pkg::LAST_LEG) state_d = lrss_pkg::ST_RD;
					else if (copy_pend_q) state_d = lrss_pkg::ST_COPY;
					else state_d = lrss_pkg::ST_IDLE;
				end
			end
			default: state_d = lrss_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lrss_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// output valid: set by the output step, cleared when the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (state_q == lrss_pkg::ST_OUT && out_free) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	// sequencing control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= lrss_pkg::PH_FOLD;
			tick_q      <= '0;
			ph_q        <= lrss_pkg::PH_FOLD;
			n_q         <= '0;
			t_q         <= '0;
			copy_pend_q <= 1'b0;
			copy_pose_q <= 1'b0;
			pose_ph_q   <= lrss_pkg::PH_FOLD;
			cnt_q       <= '0;
			leg_q       <= '0;
			div_cnt_q   <= '0;
			meas_vld_q  <= '0;
			start_vld_q <= 1'b0;
		end else begin
			if (meas_we) meas_vld_q[leg_index[LW-1:0]] <= 1'b1;
			case (state_q)
				lrss_pkg::ST_IDLE: begin
					cnt_q <= '0;
					leg_q <= '0;
					if (accept_in && operation == lrss_pkg::OP_ENTER) begin
						tick_q      <= '0;
						copy_pose_q <= 1'b0;
						phase_q     <= (!upside_down && trunk_height > lrss_pkg::H_STAND_LO &&
						                trunk_height < lrss_pkg::H_STAND_HI) ?
						               lrss_pkg::PH_STAND : lrss_pkg::PH_FOLD;
					end else if (accept_in && operation == lrss_pkg::OP_TICK) begin
						ph_q        <= ph_in;
						t_q         <= tick_q;
						case (ph_in)
							lrss_pkg::PH_STAND: begin
								n_q <= stand_ramp_q;
								if (({4'b0, tick_q} * 20'd10) <= ({8'b0, stand_ramp_q} * 20'd7))
									tick_q <= tick_inc;
								else if (upside_down || trunk_height <= lrss_pkg::H_TOO_LOW) begin
									copy_pose_q <= 1'b0;
									phase_q     <= lrss_pkg::PH_FOLD;
									tick_q      <= '0;
								end else tick_q <= CW'(1);
							end
							lrss_pkg::PH_ROLL: begin
								n_q <= roll_ramp_q;
								if ({3'b0, tick_q} > ({4'b0, roll_ramp_q} + {4'b0, roll_settle_q} +
								    19'd0)) begin
									copy_pend_q <= 1'b1;
									copy_pose_q <= 1'b1;
									pose_ph_q   <= lrss_pkg::PH_ROLL;
									phase_q     <= lrss_pkg::PH_FOLD;
									tick_q      <= '0;
								end else tick_q <= tick_inc;
							end
							default: begin
								n_q <= fold_ramp_q;
								if ({3'b0, tick_q} >= ({4'b0, fold_ramp_q} + {4'b0, fold_settle_q} +
								    19'd0)) begin
									copy_pend_q <= 1'b1;
									copy_pose_q <= 1'b1;
									pose_ph_q   <= lrss_pkg::PH_FOLD;
									phase_q     <= upside_down ? lrss_pkg::PH_ROLL : lrss_pkg::PH_STAND;
									tick_q      <= '0;
								end else tick_q <= tick_inc;
							end
						endcase
					end
				end
				lrss_pkg::ST_COPY: begin
					cnt_q <= cnt_q + (LW+1)'(1);
					if (cnt_q == (LW+1)'(lrss_pkg::NUM_LEGS)) begin
						start_vld_q <= 1'b1;
						copy_pend_q <= 1'b0;
					end
				end
				lrss_pkg::ST_MUL: div_cnt_q <= '0;
				lrss_pkg::ST_DIV: div_cnt_q <= div_cnt_q + 5'd1;
				lrss_pkg::ST_OUT: begin
					if (out_free) leg_q <= leg_q + LW'(1);
				end
				default: ;
			endcase
		end
	end

	// early-out flag: ramp done or zero ramp gives the target
	always_ff @(posedge clk) begin
		if (state_q == lrss_pkg::ST_RD)
			early_q <= (n_q == '0) || (t_q >= {4'b0, n_q});
	end

	// per-joint difference, product and restoring divider
	logic signed [AW-1:0] st_c   [NJ];
	logic signed [AW:0]   diff_c [NJ];
	logic [QW:0]          mag2_c [NJ];
	logic [30:0]          num_c  [NJ];
	logic [MW:0]          trial_c[NJ];
	logic [MW:0]          den_c;
	logic signed [AW-1:0] res_c  [NJ];

	assign den_c = {1'b0, n_q, 1'b0};

	always_comb begin
		for (int j = 0; j < NJ; j++) begin
			st_c[j]    = start_vld_q ? $signed(start_rdata[j*AW +: AW]) : '0;
			diff_c[j]  = (AW+1)'(lrss_pkg::target_of(ph_q, leg_q, j)) - (AW+1)'(st_c[j]);
			mag2_c[j]  = {mag_q[j], 1'b0};
			num_c[j]   = 31'(mag2_c[j]) * 31'(t_q[NW-1:0]) + 31'(n_q);
			trial_c[j] = {rem_q[j], quo_q[j][QW-1]};
			res_c[j]   = early_q ? lrss_pkg::target_of(ph_q, leg_q, j) :
			             (neg_q[j] ? start_q[j] - AW'(quo_q[j]) : start_q[j] + AW'(quo_q[j]));
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NJ; j++) begin
			case (state_q)
				lrss_pkg::ST_DIFF: begin
					start_q[j] <= st_c[j];
					neg_q[j]   <= diff_c[j][AW];
					mag_q[j]   <= diff_c[j][AW] ? QW'(-diff_c[j]) : QW'(diff_c[j]);
				end
				lrss_pkg::ST_MUL: begin
					rem_q[j] <= num_c[j][29:17];
					quo_q[j] <= num_c[j][16:0];
				end
				lrss_pkg::ST_DIV: begin
					if (trial_c[j] >= den_c) begin
						rem_q[j] <= MW'(trial_c[j] - den_c);
						quo_q[j] <= {quo_q[j][QW-2:0], 1'b1};
					end else begin
						rem_q[j] <= trial_c[j][MW-1:0];
						quo_q[j] <= {quo_q[j][QW-2:0], 1'b0};
					end
				end
				default: ;
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (state_q == lrss_pkg::ST_OUT && out_free) begin
			leg_number       <= 2'(leg_q);
			abduction_target <= res_c[0];
			hip_target       <= res_c[1];
			knee_target      <= res_c[2];
			kp_out           <= kp_q;
			kd_out           <= kd_q;
			current_phase    <= ph_q;
			last_leg         <= (leg_q == lrss_pkg::LAST_LEG);
		end
	end

	`LRSS_ASSERT_NOW(a_last_leg_num, out_valid && last_leg, leg_number == 2'(lrss_pkg::LAST_LEG), "last flag on wrong leg")
	`LRSS_ASSERT_NOW(a_phase_code, 1'b1, phase_q != 2'd3, "phase register holds unused code")
	`LRSS_ASSERT_NOW(a_div_bound, state_q == lrss_pkg::ST_DIV, div_cnt_q < 5'(QW), "divider ran past its steps")
	`LRSS_ASSERT_NEXT(a_fold_emits, accept_in && operation == lrss_pkg::OP_TICK && ph_in == lrss_pkg::PH_FOLD, state_q == lrss_pkg::ST_RD, "fold tick did not start emission")

endmodule

### verif/tb_legged_recovery_stand_sequencer_core.sv
// Self-checking testbench of the quadruped recovery stand sequencer core.
module tb_legged_recovery_stand_sequencer_core;

	localparam int CYCLE_LIMIT = 200000;
	localparam int QUIET_CYCLES = 150;

	typedef struct {
		logic [1:0]         op;
		logic [1:0]         leg;
		logic signed [15:0] abd;
		logic signed [15:0] hip;
		logic signed [15:0] knee;
		logic signed [15:0] height;
		logic               upside;
		bit                 drain_first;
	} cmd_t;

	typedef struct {
		logic [1:0]         leg;
		logic signed [15:0] abd;
		logic signed [15:0] hip;
		logic signed [15:0] knee;
		logic [9:0]         kp;
		logic [9:0]         kd;
		logic [1:0]         ph;
		logic               last;
	} setpoint_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] operation = '0;
	logic [1:0] leg_index = '0;
	logic signed [15:0] abduction_angle = '0;
	logic signed [15:0] hip_angle = '0;
	logic signed [15:0] knee_angle = '0;
	logic signed [15:0] trunk_height = '0;
	logic upside_down = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] leg_number;
	logic signed [15:0] abduction_target, hip_target, knee_target;
	logic [9:0] kp_out, kd_out;
	logic [1:0] current_phase;
	logic last_leg;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [11:0] cfg_data = '0;

	// predictor state
	logic [1:0] seq_phase;
	int unsigned seq_ticks;
	longint start_pose [12];
	longint meas_pose [12];
	longint unsigned ramp_regs [7];

	cmd_t pending_cmds [$];
	setpoint_t expected_setpoints [$];
	cmd_t cur_cmd;
	bit no_idle = 1'b0;
	bit hold_request = 1'b0;
	int mismatches = 0;
	int cycles = 0;
	int hold_left = 0;

	legged_recovery_stand_sequencer_core i_dut (.*);

	always #1 clk = ~clk;

	// pose angle of a leg joint in a phase
	function automatic longint pose_angle(logic [1:0] ph, int leg, int j);
		longint fold_t [3] = '{0, -5734, 11059};
		longint stand_t [3] = '{0, -3277, 6554};
		longint roll_e [3] = '{6144, -6554, 11346};
		longint roll_o [3] = '{5325, -12698, 11346};
		if (ph == lrss_pkg::PH_STAND) return stand_t[j];
		if (ph == lrss_pkg::PH_ROLL) return (leg % 2) ? roll_o[j] : roll_e[j];
		return fold_t[j];
	endfunction

	// linear ramp, rounded half away from zero
	function automatic longint ramp_point(longint ini, longint fin, longint unsigned t,
			longint unsigned n);
		longint diff;
		longint unsigned mag, q;
		if (n == 0 || t >= n) return fin;
		diff = fin - ini;
		mag = (diff < 0) ? longint'(-diff) : diff;
		q = (2 * mag * t + n) / (2 * n);
		return (diff < 0) ? ini - longint'(q) : ini + longint'(q);
	endfunction

	task automatic emit_setpoints(logic [1:0] ph, longint unsigned n);
		setpoint_t s;
		for (int leg = 0; leg < lrss_pkg::NUM_LEGS; leg++) begin
			s.leg = leg[1:0];
			s.abd = 16'(ramp_point(start_pose[leg*3], pose_angle(ph, leg, 0), seq_ticks, n));
			s.hip = 16'(ramp_point(start_pose[leg*3+1], pose_angle(ph, leg, 1), seq_ticks, n));
			s.knee = 16'(ramp_point(start_pose[leg*3+2], pose_angle(ph, leg, 2), seq_ticks, n));
			s.kp = ramp_regs[lrss_pkg::REG_KP][9:0];
			s.kd = ramp_regs[lrss_pkg::REG_KD][9:0];
			s.ph = ph;
			s.last = (leg == lrss_pkg::NUM_LEGS - 1);
			expected_setpoints.push_back(s);
		end
	endtask

	task automatic load_target_pose(logic [1:0] ph);
		for (int leg = 0; leg < lrss_pkg::NUM_LEGS; leg++)
			for (int j = 0; j < 3; j++)
				start_pose[leg*3+j] = pose_angle(ph, leg, j);
	endtask

	// advance the sequencer model by one accepted word
	task automatic sequence_step(cmd_t c);
		logic [1:0] ph;
		bit restart, hold;
		longint h;
		ph = (seq_phase == lrss_pkg::PH_STAND || seq_phase == lrss_pkg::PH_ROLL) ?
			seq_phase : lrss_pkg::PH_FOLD;
		restart = 0;
		hold = 0;
		h = c.height;
		if (c.op == lrss_pkg::OP_MEASURE) begin
			meas_pose[c.leg*3] = c.abd;
			meas_pose[c.leg*3+1] = c.hip;
			meas_pose[c.leg*3+2] = c.knee;
		end else if (c.op == lrss_pkg::OP_ENTER) begin
			seq_ticks = 0;
			start_pose = meas_pose;
			seq_phase = (!c.upside && h > 819 && h < 1843) ? lrss_pkg::PH_STAND : lrss_pkg::PH_FOLD;
		end else if (c.op == lrss_pkg::OP_TICK) begin
			if (ph == lrss_pkg::PH_STAND) begin
				if (seq_ticks <= (ramp_regs[lrss_pkg::REG_STAND_RAMP] * 7) / 10)
					emit_setpoints(lrss_pkg::PH_STAND, ramp_regs[lrss_pkg::REG_STAND_RAMP]);
				else if (c.upside || h <= 409) begin
					start_pose = meas_pose;
					seq_phase = lrss_pkg::PH_FOLD;
					restart = 1;
				end else
					hold = 1;
			end else if (ph == lrss_pkg::PH_FOLD) begin
				emit_setpoints(lrss_pkg::PH_FOLD, ramp_regs[lrss_pkg::REG_FOLD_RAMP]);
				if (seq_ticks >= ramp_regs[lrss_pkg::REG_FOLD_RAMP] +
						ramp_regs[lrss_pkg::REG_FOLD_SETTLE]) begin
					load_target_pose(lrss_pkg::PH_FOLD);
					seq_phase = c.upside ? lrss_pkg::PH_ROLL : lrss_pkg::PH_STAND;
					restart = 1;
				end
			end else begin
				emit_setpoints(lrss_pkg::PH_ROLL, ramp_regs[lrss_pkg::REG_ROLL_RAMP]);
				if (seq_ticks > ramp_regs[lrss_pkg::REG_ROLL_RAMP] +
						ramp_regs[lrss_pkg::REG_ROLL_SETTLE]) begin
					load_target_pose(lrss_pkg::PH_ROLL);
					seq_phase = lrss_pkg::PH_FOLD;
					restart = 1;
				end
			end
			if (restart) seq_ticks = 0;
			else if (hold) seq_ticks = 1;
			else if (seq_ticks < 65535) seq_ticks++;
		end
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) sequence_step(cur_cmd);
			if (!in_valid || !in_stall) begin
				if (pending_cmds.size() > 0 &&
						(!pending_cmds[0].drain_first || expected_setpoints.size() == 0) &&
						(no_idle || $urandom_range(99) >= 32)) begin
					cur_cmd = pending_cmds.pop_front();
					operation <= cur_cmd.op;
					leg_index <= cur_cmd.leg;
					abduction_angle <= cur_cmd.abd;
					hip_angle <= cur_cmd.hip;
					knee_angle <= cur_cmd.knee;
					trunk_height <= cur_cmd.height;
					upside_down <= cur_cmd.upside;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		setpoint_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_setpoints.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected setpoint word for leg %0d", leg_number);
			end else begin
				e = expected_setpoints.pop_front();
				if (leg_number !== e.leg || abduction_target !== e.abd || hip_target !== e.hip ||
						knee_target !== e.knee || kp_out !== e.kp || kd_out !== e.kd ||
						current_phase !== e.ph || last_leg !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("exp %0d %0d %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d %0d %0d",
							e.leg, e.abd, e.hip, e.knee, e.kp, e.kd, e.ph, e.last,
							leg_number, abduction_target, hip_target, knee_target,
							kp_out, kd_out, current_phase, last_leg);
				end
			end
		end
	end

	// output stall generator with a counted long hold-off
	always @(posedge clk) begin
		if (hold_request && hold_left == 0) hold_left = 400;
		if (hold_left > 0) begin
			hold_left--;
			if (hold_left == 0) hold_request = 0;
			out_stall <= 1'b1;
		end else
			out_stall <= !no_idle && ($urandom_range(99) < 32);
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic cmd_t make_cmd(logic [1:0] op, int leg, int abd, int hip,
			int knee, int height, int upside);
		cmd_t c;
		c.op = op;
		c.leg = 2'(leg);
		c.abd = 16'(abd);
		c.hip = 16'(hip);
		c.knee = 16'(knee);
		c.height = 16'(height);
		c.upside = 1'(upside);
		c.drain_first = 0;
		return c;
	endfunction

	function automatic int pick_height();
		int marks [8] = '{409, 410, 819, 820, 1842, 1843, -32768, 32767};
		case ($urandom_range(3))
			0: return $urandom_range(2047);
			1: return marks[$urandom_range(7)];
			2: return $signed(16'($urandom));
			default: return 1000 + $urandom_range(600);
		endcase
	endfunction

	function automatic cmd_t random_cmd(logic [1:0] op);
		return make_cmd(op, 2'($urandom), $signed(16'($urandom)), $signed(16'($urandom)),
			$signed(16'($urandom)), pick_height(), 1'($urandom));
	endfunction

	// a recovery run: measure all legs, enter, then a burst of ticks mixed with random words
	task automatic queue_recovery(int ticks);
		for (int leg = 0; leg < lrss_pkg::NUM_LEGS; leg++) begin
			pending_cmds.push_back(random_cmd(lrss_pkg::OP_MEASURE));
			pending_cmds[$].leg = leg[1:0];
		end
		pending_cmds.push_back(random_cmd(lrss_pkg::OP_ENTER));
		for (int k = 0; k < ticks; k++) begin
			if ($urandom_range(9) == 0)
				pending_cmds.push_back(random_cmd(2'($urandom_range(3))));
			pending_cmds.push_back(random_cmd(lrss_pkg::OP_TICK));
			if ($urandom_range(5) != 0) pending_cmds[$].upside = pending_cmds[$-1].upside;
		end
	endtask

	task automatic wait_idle();
		while (pending_cmds.size() > 0 || in_valid || expected_setpoints.size() > 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(int sr, int fr, int fs, int rr, int rs, int kp, int kd);
		int vals [7];
		vals = '{sr, fr, fs, rr, rs, kp, kd};
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= 12'(vals[i]);
			@(posedge clk);
			ramp_regs[i] = (i >= lrss_pkg::REG_KP) ? vals[i] & 12'h3FF : vals[i] & 12'hFFF;
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		seq_phase = lrss_pkg::PH_FOLD;
		seq_ticks = 0;
		foreach (start_pose[i]) begin
			start_pose[i] = 0;
			meas_pose[i] = 0;
		end
		ramp_regs = '{250, 400, 700, 150, 150, 80, 1};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of angles and heights, band edges, ignored op
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_MEASURE, 0, 32767, 32767, 32767, 0, 0));
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_MEASURE, 1, -32768, -32768, -32768, 0, 1));
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_MEASURE, 2, 1234, -4321, 32767, 0, 0));
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_MEASURE, 3, -1, 1, 0, 0, 0));
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_ENTER, 0, 0, 0, 0, 1000, 0));
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_TICK, 0, 0, 0, 0, 1000, 0));
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_TICK, 0, 0, 0, 0, 1000, 0));
		pending_cmds.push_back(make_cmd(2'd3, 3, -1, -1, -1, -1, 1));
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_ENTER, 0, 0, 0, 0, 819, 0));
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_TICK, 0, 0, 0, 0, 819, 0));
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_ENTER, 0, 0, 0, 0, 1843, 0));
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_ENTER, 0, 0, 0, 0, 820, 1));
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_TICK, 0, 0, 0, 0, 820, 1));
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_ENTER, 0, 0, 0, 0, -32768, 0));
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_ENTER, 0, 0, 0, 0, 32767, 0));
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_ENTER, 0, 0, 0, 0, 1842, 0));
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_TICK, 0, 0, 0, 0, 1842, 0));
		pending_cmds.push_back(make_cmd(lrss_pkg::OP_TICK, 0, 0, 0, 0, 1842, 1));
		wait_idle();

		// minimum ramps, no settle: fast phase changes, no idling
		write_regs(1, 1, 0, 1, 0, 0, 0);
		no_idle = 1;
		queue_recovery(20);
		wait_idle();
		no_idle = 0;

		// maximum ramps and gains, with a long output hold-off
		write_regs(4095, 4095, 4095, 4095, 4095, 1023, 1023);
		hold_request = 1;
		queue_recovery(12);
		wait_idle();

		// zero ramps jump straight to the target
		write_regs(0, 0, 0, 0, 0, 12'hFFF, 12'hC00);
		queue_recovery(14);
		wait_idle();

		// small random settings, one pause for a full drain
		for (int p = 0; p < 2; p++) begin
			write_regs($urandom_range(1, 9), $urandom_range(1, 6), $urandom_range(0, 5),
				$urandom_range(1, 6), $urandom_range(0, 5), $urandom, $urandom);
			queue_recovery(10);
			if (p == 1) pending_cmds[$-5].drain_first = 1;
			queue_recovery(4);
			wait_idle();
		end

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
